### rtl/core/psc_pkg.sv
package psc_pkg;

    // gain registers are signed q12.12 words
    localparam int GAIN_WIDTH = 24;

    // clamped drive command
    localparam int DRIVE_WIDTH = 9;
    localparam int DRIVE_LIMIT = 255;

    // result word: drive_value, clamped, zero fill to a whole byte count
    localparam int OUT_TDATA_WIDTH = ((DRIVE_WIDTH + 1 + 7) / 8) * 8;

    // configuration register map
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_KP_GAIN       = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_KI_PER_SAMPLE = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_KD_PER_SAMPLE = 2'd2;

    // register reset values
    localparam logic signed [GAIN_WIDTH-1:0] KP_GAIN_RESET       = 24'sd4096;
    localparam logic signed [GAIN_WIDTH-1:0] KI_PER_SAMPLE_RESET = 24'sd8;
    localparam logic signed [GAIN_WIDTH-1:0] KD_PER_SAMPLE_RESET = 24'sd2048000;

endpackage

### rtl/core/pid_speed_controller_core.sv
// pid speed loop with derivative taken on the measurement. each input word
// carries a goal and a measured speed; each one yields exactly one result word
// holding the drive command, clamped to +/-255, and a flag set when clamping
// happened. the block takes one word per clock and passes it through its
// registered error, multiply and sum stages; the error integral and
// the last measurement are updated as the word is accepted, so back-to-back
// words see each other's state. throughput drops only when the result side
// holds tready low. gains are signed q12.12; the user must write them through the
// configuration port only while no word is in flight, as the block does not enforce
// it; the sample period is folded into the integral and derivative gains by software.
module pid_speed_controller_core #(
    parameter int SPEED_WIDTH    = 16,
    parameter int GAIN_FRAC_BITS = 12,
    parameter int INTEGRAL_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [psc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [psc_pkg::GAIN_WIDTH-1:0]        cfg_data,

    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // goal_speed, measured_speed, zero fill
    input  logic [((2*SPEED_WIDTH+7)/8)*8-1:0]    s_axis_tdata,

    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // drive_value, clamped, zero fill
    output logic [psc_pkg::OUT_TDATA_WIDTH-1:0]   m_axis_tdata
);

    localparam int GW = psc_pkg::GAIN_WIDTH;

    // gain registers
    logic signed [GW-1:0] kp_gain_reg;
    logic signed [GW-1:0] ki_per_sample_reg;
    logic signed [GW-1:0] kd_per_sample_reg;

    // input field split
    logic signed [SPEED_WIDTH-1:0] goal_speed;
    logic signed [SPEED_WIDTH-1:0] measured_speed;

    // error stage to multiply stage
    logic                             err_valid;
    logic                             err_ready;
    logic signed [SPEED_WIDTH:0]      error;
    logic signed [SPEED_WIDTH:0]      delta;
    logic signed [INTEGRAL_WIDTH-1:0] integral;

    // multiply stage to sum stage
    logic                                 mul_valid;
    logic                                 mul_ready;
    logic signed [GW+SPEED_WIDTH:0]       p_term;
    logic signed [GW+INTEGRAL_WIDTH-1:0]  i_term;
    logic signed [GW+SPEED_WIDTH:0]       d_term;

    // result fields
    logic signed [psc_pkg::DRIVE_WIDTH-1:0] drive_value;
    logic                                   clamped;

    // register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_gain_reg       <= psc_pkg::KP_GAIN_RESET;
            ki_per_sample_reg <= psc_pkg::KI_PER_SAMPLE_RESET;
            kd_per_sample_reg <= psc_pkg::KD_PER_SAMPLE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                psc_pkg::REG_KP_GAIN:       kp_gain_reg       <= cfg_data;
                psc_pkg::REG_KI_PER_SAMPLE: ki_per_sample_reg <= cfg_data;
                psc_pkg::REG_KD_PER_SAMPLE: kd_per_sample_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign goal_speed     = s_axis_tdata[SPEED_WIDTH-1:0];
    assign measured_speed = s_axis_tdata[2*SPEED_WIDTH-1:SPEED_WIDTH];

    // error, derivative delta and saturating integral; loop state lives here
    psc_error_stage #(
        .SPEED_WIDTH    (SPEED_WIDTH),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_error_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .goal_speed     (goal_speed),
        .measured_speed (measured_speed),
        .out_valid      (err_valid),
        .out_ready      (err_ready),
        .error          (error),
        .delta          (delta),
        .integral       (integral)
    );

    // three gain products, registered
    psc_mult_stage #(
        .SPEED_WIDTH    (SPEED_WIDTH),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_mult_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (err_valid),
        .in_ready       (err_ready),
        .error          (error),
        .delta          (delta),
        .integral       (integral),
        .kp_gain        (kp_gain_reg),
        .ki_per_sample  (ki_per_sample_reg),
        .kd_per_sample  (kd_per_sample_reg),
        .out_valid      (mul_valid),
        .out_ready      (mul_ready),
        .p_term         (p_term),
        .i_term         (i_term),
        .d_term         (d_term)
    );

    // sum, q12 rescale, clamp; holds the result word
    psc_sum_stage #(
        .SPEED_WIDTH    (SPEED_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_sum_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (mul_valid),
        .in_ready       (mul_ready),
        .p_term         (p_term),
        .i_term         (i_term),
        .d_term         (d_term),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .drive_value    (drive_value),
        .clamped        (clamped)
    );

    assign m_axis_tdata = {{(psc_pkg::OUT_TDATA_WIDTH-psc_pkg::DRIVE_WIDTH-1){1'b0}},
                           clamped, drive_value};

endmodule

### rtl/core/psc_error_stage.sv
module psc_error_stage #(
    parameter int SPEED_WIDTH    = 16,
    parameter int INTEGRAL_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [SPEED_WIDTH-1:0]    goal_speed,
    input  logic signed [SPEED_WIDTH-1:0]    measured_speed,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [SPEED_WIDTH:0]      error,
    output logic signed [SPEED_WIDTH:0]      delta,
    output logic signed [INTEGRAL_WIDTH-1:0] integral
);

    localparam int EW = ((INTEGRAL_WIDTH > SPEED_WIDTH + 1) ?
                         INTEGRAL_WIDTH : SPEED_WIDTH + 1) + 1;

    logic                             valid_reg;
    logic signed [SPEED_WIDTH:0]      error_reg;
    logic signed [SPEED_WIDTH:0]      delta_reg;
    logic signed [INTEGRAL_WIDTH-1:0] integral_out_reg;
    logic signed [INTEGRAL_WIDTH-1:0] error_integral_reg;
    logic signed [SPEED_WIDTH-1:0]    last_measured_reg;

    logic                             accept;
    logic signed [SPEED_WIDTH:0]      error_next;
    logic signed [SPEED_WIDTH:0]      delta_next;
    logic [EW-1:0]                    integral_wide;
    logic [EW-INTEGRAL_WIDTH:0]       integral_top;
    logic signed [INTEGRAL_WIDTH-1:0] integral_next;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign error_next = {goal_speed[SPEED_WIDTH-1], goal_speed}
                      - {measured_speed[SPEED_WIDTH-1], measured_speed};
    assign delta_next = {measured_speed[SPEED_WIDTH-1], measured_speed}
                      - {last_measured_reg[SPEED_WIDTH-1], last_measured_reg};

    assign integral_wide =
        {{(EW-INTEGRAL_WIDTH){error_integral_reg[INTEGRAL_WIDTH-1]}}, error_integral_reg}
      + {{(EW-SPEED_WIDTH-1){error_next[SPEED_WIDTH]}}, error_next};
    assign integral_top = integral_wide[EW-1:INTEGRAL_WIDTH-1];

    // saturate at the signed integral range
    always_comb
    begin
        if ((&integral_top) || !(|integral_top))
        begin
            integral_next = integral_wide[INTEGRAL_WIDTH-1:0];
        end
        else if (integral_wide[EW-1])
        begin
            integral_next = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};
        end
        else
        begin
            integral_next = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg          <= 1'b0;
            error_integral_reg <= '0;
            last_measured_reg  <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (accept)
            begin
                error_integral_reg <= integral_next;
                last_measured_reg  <= measured_speed;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            error_reg        <= error_next;
            delta_reg        <= delta_next;
            integral_out_reg <= integral_next;
        end
    end

    assign out_valid = valid_reg;
    assign error     = error_reg;
    assign delta     = delta_reg;
    assign integral  = integral_out_reg;

endmodule

### rtl/core/psc_mult_stage.sv
module psc_mult_stage #(
    parameter int SPEED_WIDTH    = 16,
    parameter int INTEGRAL_WIDTH = 32
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  in_valid,
    output logic                                                  in_ready,
    input  logic signed [SPEED_WIDTH:0]                           error,
    input  logic signed [SPEED_WIDTH:0]                           delta,
    input  logic signed [INTEGRAL_WIDTH-1:0]                      integral,
    input  logic signed [psc_pkg::GAIN_WIDTH-1:0]                 kp_gain,
    input  logic signed [psc_pkg::GAIN_WIDTH-1:0]                 ki_per_sample,
    input  logic signed [psc_pkg::GAIN_WIDTH-1:0]                 kd_per_sample,
    output logic                                                  out_valid,
    input  logic                                                  out_ready,
    output logic signed [psc_pkg::GAIN_WIDTH+SPEED_WIDTH:0]       p_term,
    output logic signed [psc_pkg::GAIN_WIDTH+INTEGRAL_WIDTH-1:0]  i_term,
    output logic signed [psc_pkg::GAIN_WIDTH+SPEED_WIDTH:0]       d_term
);

    localparam int PW = psc_pkg::GAIN_WIDTH + SPEED_WIDTH + 1;
    localparam int IW = psc_pkg::GAIN_WIDTH + INTEGRAL_WIDTH;

    logic                 valid_reg;
    logic signed [PW-1:0] p_term_reg;
    logic signed [IW-1:0] i_term_reg;
    logic signed [PW-1:0] d_term_reg;

    logic                 advance;
    logic signed [PW-1:0] p_term_next;
    logic signed [IW-1:0] i_term_next;
    logic signed [PW-1:0] d_term_next;

    assign in_ready = !valid_reg || out_ready;
    assign advance  = in_valid && in_ready;

    assign p_term_next = kp_gain * error;
    assign i_term_next = ki_per_sample * integral;
    assign d_term_next = kd_per_sample * delta;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_term_reg <= p_term_next;
            i_term_reg <= i_term_next;
            d_term_reg <= d_term_next;
        end
    end

    assign out_valid = valid_reg;
    assign p_term    = p_term_reg;
    assign i_term    = i_term_reg;
    assign d_term    = d_term_reg;

endmodule

### rtl/core/psc_sum_stage.sv
module psc_sum_stage #(
    parameter int SPEED_WIDTH    = 16,
    parameter int GAIN_FRAC_BITS = 12,
    parameter int INTEGRAL_WIDTH = 32
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  in_valid,
    output logic                                                  in_ready,
    input  logic signed [psc_pkg::GAIN_WIDTH+SPEED_WIDTH:0]       p_term,
    input  logic signed [psc_pkg::GAIN_WIDTH+INTEGRAL_WIDTH-1:0]  i_term,
    input  logic signed [psc_pkg::GAIN_WIDTH+SPEED_WIDTH:0]       d_term,
    output logic                                                  out_valid,
    input  logic                                                  out_ready,
    output logic signed [psc_pkg::DRIVE_WIDTH-1:0]                drive_value,
    output logic                                                  clamped
);

    localparam int PW = psc_pkg::GAIN_WIDTH + SPEED_WIDTH + 1;
    localparam int IW = psc_pkg::GAIN_WIDTH + INTEGRAL_WIDTH;
    localparam int SW = ((PW > IW) ? PW : IW) + 2;

    localparam logic signed [SW-1:0] LIMIT_HI = SW'(psc_pkg::DRIVE_LIMIT);
    localparam logic signed [SW-1:0] LIMIT_LO = -LIMIT_HI;

    logic                                   valid_reg;
    logic signed [psc_pkg::DRIVE_WIDTH-1:0] drive_value_reg;
    logic                                   clamped_reg;

    logic                                   advance;
    logic signed [SW-1:0]                   sum;
    logic signed [SW-1:0]                   scaled;
    logic signed [psc_pkg::DRIVE_WIDTH-1:0] drive_value_next;
    logic                                   clamped_next;

    assign in_ready = !valid_reg || out_ready;
    assign advance  = in_valid && in_ready;

    assign sum = {{(SW-PW){p_term[PW-1]}}, p_term}
               + {{(SW-IW){i_term[IW-1]}}, i_term}
               - {{(SW-PW){d_term[PW-1]}}, d_term};

    // arithmetic shift rounds toward minus infinity
    assign scaled = sum >>> GAIN_FRAC_BITS;

    always_comb
    begin
        if (scaled > LIMIT_HI)
        begin
            drive_value_next = LIMIT_HI[psc_pkg::DRIVE_WIDTH-1:0];
            clamped_next     = 1'b1;
        end
        else if (scaled < LIMIT_LO)
        begin
            drive_value_next = LIMIT_LO[psc_pkg::DRIVE_WIDTH-1:0];
            clamped_next     = 1'b1;
        end
        else
        begin
            drive_value_next = scaled[psc_pkg::DRIVE_WIDTH-1:0];
            clamped_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_value_reg <= drive_value_next;
            clamped_reg     <= clamped_next;
        end
    end

    assign out_valid   = valid_reg;
    assign drive_value = drive_value_reg;
    assign clamped     = clamped_reg;

endmodule
